FILE: hdl/teq_pkg.sv
package teq_pkg;

    // Widths of the event fields and of the stream payloads.
    localparam int TIME_W  = 32;
    localparam int TYPE_W  = 4;
    localparam int CMD_W   = 3;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 72;

    // Reported as the next due time when no event is pending.
    localparam logic [TIME_W-1:0] NO_EVENTS = 32'hffff_ffff;

    // Reset value of the frame length register.
    localparam logic [TIME_W-1:0] FRAME_LEN_INIT = 32'd69888;

    // The null event type.
    localparam logic [TYPE_W-1:0] TYPE_NULL = 4'd0;

    // Command codes carried on s_tuser.
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REBASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Result kinds carried on m_tuser.
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

    // One queue slot.
    typedef struct packed {
        logic [TYPE_W-1:0] ev_type;
        logic [TIME_W-1:0] ev_time;
    } entry_t;

    // Result of the shared subtractor.
    typedef struct packed {
        logic [TIME_W-1:0] diff;
        logic              borrow;
        logic              zero;
    } alu_res_t;

endpackage

FILE: hdl/teq_alu.sv
module teq_alu (
    input  logic [teq_pkg::TIME_W-1:0] op_a,
    input  logic [teq_pkg::TIME_W-1:0] op_b,
    output teq_pkg::alu_res_t          res
);
    import teq_pkg::*;

    logic [TIME_W:0] wide_diff;

    // One 32-bit subtractor serves ordering compares and rebasing alike.
    // A borrow means op_a is below op_b.
    assign wide_diff  = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff   = wide_diff[TIME_W-1:0];
    assign res.borrow = wide_diff[TIME_W];
    assign res.zero   = (op_a == op_b);

endmodule

FILE: hdl/timed_event_queue_top.sv
// Timed event queue: keeps up to DEPTH pending events (due time, type) in a
// circular slot memory, ordered by time and then type, and works one command
// at a time. Each memory read goes through the single read port with a
// registered read, and every time compare or subtraction uses one shared
// 32-bit subtractor. An add, a rebase and a remove-type walk the held
// events; an add to a full queue, unused commands and clear go straight to
// the final report; dispatch pops due heads and emits each popped event
// that is not of the null type. s_tready is high only while no command is
// in progress; results leave through an output register, so a stalled
// m_tready only holds the sequencer at the cycle where it wants to emit,
// and adds the stalled cycles to the step.
module timed_event_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [teq_pkg::TIME_W-1:0]  cfg_wdata,   // frame_length
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [31:0] add_time, [35:32] event_type, [67:36] current_time, rest zero
    input  logic [teq_pkg::TDATA_W-1:0] s_tdata,
    // [2:0] command
    input  logic [teq_pkg::CMD_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [31:0] due_time, [35:32] due_type, [67:36] next_due, rest zero
    output logic [teq_pkg::TDATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [teq_pkg::KIND_W-1:0]  m_tuser,
    output logic                        m_tlast
);
    import teq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_FIN_RD,
        ST_FIN_CMP
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       occ_reg;
    logic [IW-1:0]       head_reg;
    logic [CW-1:0]       idx_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TYPE_W-1:0]   rm_type_reg;
    logic [TIME_W-1:0]   frame_len_reg;
    entry_t              carry_reg;
    logic                inserted_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                pend_valid_reg;
    entry_t              pend_reg;
    entry_t              rd_data_reg;

    logic                m_tvalid_reg;
    logic [KIND_W-1:0]   m_kind_reg;
    logic [TIME_W-1:0]   m_due_time_reg;
    logic [TYPE_W-1:0]   m_due_type_reg;
    logic [TIME_W-1:0]   m_next_due_reg;
    logic                m_last_reg;

    entry_t              slot_mem [DEPTH];

    logic                out_free;
    logic                out_load;
    logic                idx_at_end;
    logic                occ_empty;
    logic                occ_full;
    logic [IW-1:0]       idx_addr;
    logic [IW-1:0]       head_inc;
    logic [TIME_W-1:0]   alu_a;
    logic [TIME_W-1:0]   alu_b;
    alu_res_t            alu_res;
    logic                add_swap;
    logic                head_due;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    entry_t              rmw_data;

    // Physical slot of a logical offset from the head, wrapping at DEPTH.
    function automatic logic [IW-1:0] slot_addr(input logic [IW-1:0] base,
                                                input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(DEPTH)) begin
            sum = sum - (IW+1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // Status decodes.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign idx_at_end = (idx_reg == occ_reg);
    assign occ_empty  = (occ_reg == '0);
    assign occ_full   = (occ_reg == CW'(DEPTH));
    assign idx_addr   = slot_addr(head_reg, idx_reg[IW-1:0]);
    assign head_inc   = slot_addr(head_reg, IW'(1));

    // Operand selection for the shared subtractor.
    always_comb begin
        case (state_reg)
            ST_FIN_CMP: begin
                alu_a = now_reg;
                alu_b = rd_data_reg.ev_time;
            end
            ST_ADD_CMP: begin
                alu_a = rd_data_reg.ev_time;
                alu_b = carry_reg.ev_time;
            end
            default: begin
                alu_a = rd_data_reg.ev_time;
                alu_b = frame_len_reg;
            end
        endcase
    end

    teq_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    // The carried entry goes into this slot when it orders at or before the
    // stored one; from then on every later entry moves up by one slot.
    assign add_swap = inserted_reg ||
                      (!alu_res.borrow &&
                       (!alu_res.zero || (carry_reg.ev_type <= rd_data_reg.ev_type)));

    // The head is due when current_time is not below its time.
    assign head_due = (cmd_reg == CMD_DISP) && !alu_res.borrow;

    // The sequencer loads a new result into the output register.
    assign out_load = out_free &&
                      (((state_reg == ST_FIN_RD) && occ_empty) ||
                       ((state_reg == ST_FIN_CMP) && (pend_valid_reg || !head_due)));

    // Read-modify-write value for rebase and remove-type.
    always_comb begin
        rmw_data = rd_data_reg;
        if (cmd_reg == CMD_REBASE) begin
            rmw_data.ev_time = alu_res.diff;
        end else if (rd_data_reg.ev_type == rm_type_reg) begin
            rmw_data.ev_type = TYPE_NULL;
        end
    end

    // Memory port control.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = idx_addr;
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = carry_reg;
        case (state_reg)
            ST_ADD_RD: begin
                mem_re = !idx_at_end;
                mem_we = idx_at_end;
            end
            ST_ADD_CMP: begin
                mem_we = add_swap;
            end
            ST_RMW_RD: begin
                mem_re = !idx_at_end;
            end
            ST_RMW_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rmw_data;
            end
            ST_FIN_RD: begin
                mem_re    = !occ_empty;
                mem_raddr = head_reg;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Slot memory with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // Sequencer, queue bookkeeping and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            frame_len_reg  <= FRAME_LEN_INIT;
        end else begin
            if (cfg_wen) begin
                frame_len_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg        <= s_tuser;
                        now_reg        <= s_tdata[67:36];
                        rm_type_reg    <= s_tdata[35:32];
                        carry_reg      <= {s_tdata[35:32], s_tdata[31:0]};
                        inserted_reg   <= 1'b0;
                        idx_reg        <= '0;
                        kind_reg       <= KIND_DONE;
                        pend_valid_reg <= 1'b0;
                        case (s_tuser)
                            CMD_ADD: begin
                                if (occ_full) begin
                                    kind_reg  <= KIND_FULL;
                                    state_reg <= ST_FIN_RD;
                                end else begin
                                    state_reg <= ST_ADD_RD;
                                end
                            end
                            CMD_REBASE, CMD_REMOVE: begin
                                state_reg <= ST_RMW_RD;
                            end
                            CMD_CLEAR: begin
                                occ_reg   <= '0;
                                state_reg <= ST_FIN_RD;
                            end
                            default: begin
                                state_reg <= ST_FIN_RD;
                            end
                        endcase
                    end
                end

                // Insertion: one pass from the head, carrying displaced entries up.
                ST_ADD_RD: begin
                    if (idx_at_end) begin
                        occ_reg   <= occ_reg + CW'(1);
                        state_reg <= ST_FIN_RD;
                    end else begin
                        state_reg <= ST_ADD_CMP;
                    end
                end

                ST_ADD_CMP: begin
                    if (add_swap) begin
                        carry_reg    <= rd_data_reg;
                        inserted_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_ADD_RD;
                end

                // Rebase and remove-type walk every held entry in place.
                ST_RMW_RD: begin
                    if (idx_at_end) begin
                        state_reg <= ST_FIN_RD;
                    end else begin
                        state_reg <= ST_RMW_WR;
                    end
                end

                ST_RMW_WR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_RMW_RD;
                end

                // Read the head; with an empty queue emit any popped event, then report.
                ST_FIN_RD: begin
                    if (!occ_empty) begin
                        state_reg <= ST_FIN_CMP;
                    end else if (out_free) begin
                        m_next_due_reg <= NO_EVENTS;
                        if (pend_valid_reg) begin
                            m_kind_reg     <= KIND_EVENT;
                            m_due_time_reg <= pend_reg.ev_time;
                            m_due_type_reg <= pend_reg.ev_type;
                            m_last_reg     <= 1'b0;
                            pend_valid_reg <= 1'b0;
                        end else begin
                            m_kind_reg     <= kind_reg;
                            m_due_time_reg <= '0;
                            m_due_type_reg <= TYPE_NULL;
                            m_last_reg     <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end

                // Head known: emit a popped event, pop a due head, or finish.
                ST_FIN_CMP: begin
                    if (pend_valid_reg) begin
                        if (out_free) begin
                            m_kind_reg     <= KIND_EVENT;
                            m_due_time_reg <= pend_reg.ev_time;
                            m_due_type_reg <= pend_reg.ev_type;
                            m_next_due_reg <= rd_data_reg.ev_time;
                            m_last_reg     <= 1'b0;
                            pend_valid_reg <= 1'b0;
                        end
                    end else if (head_due) begin
                        head_reg       <= head_inc;
                        occ_reg        <= occ_reg - CW'(1);
                        pend_valid_reg <= (rd_data_reg.ev_type != TYPE_NULL);
                        pend_reg       <= rd_data_reg;
                        state_reg      <= ST_FIN_RD;
                    end else if (out_free) begin
                        m_kind_reg     <= kind_reg;
                        m_due_time_reg <= '0;
                        m_due_type_reg <= TYPE_NULL;
                        m_next_due_reg <= rd_data_reg.ev_time;
                        m_last_reg     <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Port drive.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0000, m_next_due_reg, m_due_type_reg, m_due_time_reg};

endmodule
